>>> rtl/core/header_length_checksum_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define HLCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HLCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hlcfp_pkg.sv
// ----------------------------------------------------------------------------
// hlcfp_pkg
// Types and constants shared by the frame parser controller and datapath.
// ----------------------------------------------------------------------------
package hlcfp_pkg;

  localparam int HLCFP_DEPTH      = 64;
  localparam int HLCFP_IDX_W      = $clog2(HLCFP_DEPTH);
  localparam int HLCFP_MAX_LENGTH = 63;
  localparam int HLCFP_EFF_MAX_I  =
    (HLCFP_MAX_LENGTH > HLCFP_DEPTH - 1) ? HLCFP_DEPTH - 1 : HLCFP_MAX_LENGTH;
  localparam logic [7:0] HLCFP_EFF_MAX   = 8'(HLCFP_EFF_MAX_I);
  localparam logic [7:0] HLCFP_HDR_RESET = 8'hEE;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_CSUM = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;       // accept rx_byte this cycle
    logic fetch;      // read frame store at readout index
    logic load_byte;  // move fetched byte into the output register
    logic load_err;   // load a checksum-error transaction
  } hlcfp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_end;  // incoming byte is the checksum byte
    logic sum_ok;     // incoming byte matches the running sum
    logic rd_last;    // readout index is at the frame's last byte
    logic out_free;   // output register can take a new transaction
  } hlcfp_status_t;

endpackage

>>> rtl/core/hlcfp_ctrl.sv
// ----------------------------------------------------------------------------
// hlcfp_ctrl
// Sequencer: receive bytes, then read a good frame out or post an error.
// ----------------------------------------------------------------------------
module hlcfp_ctrl
  import hlcfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hlcfp_status_t st,
  output hlcfp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_RECV,
    S_FETCH,
    S_LOAD,
    S_ERR
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_RECV) && in_valid;
    cmd.fetch     = (state == S_FETCH);
    cmd.load_byte = (state == S_LOAD) && st.out_free;
    cmd.load_err  = (state == S_ERR) && st.out_free;
  end

  assign in_stall = (state != S_RECV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      case (state)
        S_RECV: begin
          if (cmd.take && st.frame_end) begin
            state <= st.sum_ok ? S_FETCH : S_ERR;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (st.out_free) begin
            state <= st.rd_last ? S_RECV : S_FETCH;
          end
        end
        S_ERR: begin
          if (st.out_free) begin
            state <= S_RECV;
          end
        end
        default: begin
          state <= S_RECV;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/hlcfp_dp.sv
// ----------------------------------------------------------------------------
// hlcfp_dp
// Frame store, length and checksum tracking, readout and output register.
// ----------------------------------------------------------------------------
`include "header_length_checksum_frame_parser_assert.svh"

module hlcfp_dp
  import hlcfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             rx_byte,
  input  hlcfp_cmd_t             cmd,
  output hlcfp_status_t          st,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_byte,
  output logic [HLCFP_IDX_W-1:0] byte_index,
  output logic                   last,
  output logic                   status
);

  logic [7:0]             header_byte;
  logic [HLCFP_IDX_W-1:0] pos;
  logic [HLCFP_IDX_W-1:0] exp_len;
  logic [7:0]             running_sum;
  logic [HLCFP_IDX_W-1:0] end_idx;
  logic [HLCFP_IDX_W-1:0] rd_idx;
  logic [7:0]             mem_q;
  logic [7:0]             store [HLCFP_DEPTH];

  logic                   is_hunt;
  logic                   is_len;
  logic                   bad_len;
  logic                   hdr_hit;
  logic [HLCFP_IDX_W-1:0] cur_len;
  logic                   wr_en;

  always_comb begin
    is_hunt = (pos == '0);
    is_len  = (pos == HLCFP_IDX_W'(1));
    bad_len = (rx_byte == 8'd0) || (rx_byte > HLCFP_EFF_MAX);
    hdr_hit = (rx_byte == header_byte);
    cur_len = is_len ? rx_byte[HLCFP_IDX_W-1:0] : exp_len;
    wr_en   = cmd.take && (is_hunt ? hdr_hit : !(is_len && bad_len));

    st.frame_end = !is_hunt && !(is_len && bad_len) && (pos == cur_len);
    st.sum_ok    = (rx_byte == running_sum);
    st.rd_last   = (rd_idx == end_idx);
    st.out_free  = !out_valid || !out_stall;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HLCFP_HDR_RESET;
    end else if (cfg_write) begin
      header_byte <= cfg_data;
    end
  end

  // Receive-side tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      exp_len     <= '0;
      running_sum <= '0;
      end_idx     <= '0;
      rd_idx      <= '0;
    end else begin
      if (cmd.take) begin
        rd_idx <= '0;
        if (is_hunt) begin
          if (hdr_hit) begin
            pos         <= HLCFP_IDX_W'(1);
            running_sum <= rx_byte;
          end
        end else if ((is_len && bad_len) || st.frame_end) begin
          // drop back to header hunting
          pos         <= '0;
          exp_len     <= '0;
          running_sum <= '0;
          end_idx     <= pos;
        end else begin
          exp_len     <= cur_len;
          running_sum <= running_sum + rx_byte;
          pos         <= pos + HLCFP_IDX_W'(1);
        end
      end else if (cmd.load_byte) begin
        rd_idx <= rd_idx + HLCFP_IDX_W'(1);
      end
    end
  end

  // Frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[pos] <= rx_byte;
    end
    if (cmd.fetch) begin
      mem_q <= store[rd_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      frame_byte <= mem_q;
      byte_index <= rd_idx;
      last       <= st.rd_last;
      status     <= STATUS_GOOD;
    end else if (cmd.load_err) begin
      frame_byte <= 8'd0;
      byte_index <= '0;
      last       <= 1'b1;
      status     <= STATUS_CSUM;
    end
  end

  `HLCFP_ASSERT_NOW(a_pos_within_len, pos > HLCFP_IDX_W'(1), pos <= exp_len, "position beyond length")
  `HLCFP_ASSERT_NOW(a_rd_within_end, cmd.fetch || cmd.load_byte, rd_idx <= end_idx, "readout past frame end")
  `HLCFP_ASSERT_NOW(a_load_when_free, cmd.load_byte || cmd.load_err, !out_valid || !out_stall, "output overwritten")
  `HLCFP_ASSERT_NEXT(a_take_no_readout, cmd.take, !cmd.load_byte, "readout right after take")

endmodule

>>> rtl/core/header_length_checksum_frame_parser.sv
// ----------------------------------------------------------------------------
// header_length_checksum_frame_parser
// Byte-stream frame parser: header, length, payload, 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Bytes are taken one per transaction on the rx channel; each is accepted
// while the parser is receiving. Bytes are skipped until one equals
// header_byte (reset 0xEE). The next byte is the length L (1..63; 0 or larger
// values drop back to hunting). The byte at index L must equal the wrapping
// 8-bit sum of bytes 0..L-1. On a match the stored frame (L+1 bytes) is read
// back from the 64-entry frame store and sent out in order, the last one
// flagged; on a mismatch one error transaction (status 1, frame_byte 0, last
// 1) is sent. During readout in_stall is high: each frame byte takes one store
// read and then one output load, the load waiting while the output stalls, so
// the input is held until the whole frame has been loaded. The output register
// lets a new byte be taken while the final transaction of a frame still waits.
// header_byte may be rewritten only while the parser is idle.
module header_length_checksum_frame_parser
  import hlcfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [7:0]             cfg_data,
  // received bytes
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  // parsed frame transactions
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_byte,
  output logic [HLCFP_IDX_W-1:0] byte_index,
  output logic                   last,
  output logic                   status
);

  hlcfp_cmd_t    cmd;
  hlcfp_status_t st;

  // Sequencer: decides when to take a byte, read out, or post an error
  hlcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: store, sum, length, readout index and output register
  hlcfp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last),
    .status     (status)
  );

endmodule
